/* design/chained_hash_map_assert.svh */
// ----------------------------------------------------------------------------
// chained_hash_map_assert.svh
// Assertion macros used by the hash map top level.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH

// Implication checked at every edge, quiet during reset.
`define CHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/chm_pkg.sv */
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, codes and defaults of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned BucketsDef = 256;
  localparam int unsigned NodesDef   = 1024;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_LOAD,
    S_WALK,
    S_CHK,
    S_ACT,
    S_FREE_RD,
    S_INS,
    S_LINK,
    S_REL,
    S_FIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic hash;
    logic load;
    logic walk;
    logic chk;
    logic act;
    logic sel_free;
    logic ins;
    logic link;
    logic rel;
    logic fin;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic       hash_done;
    logic       cur_nil;
    logic       key_lt;
    logic       hit;
    logic       free_nil;
    logic       out_free;
    logic [1:0] func;
  } stat_t;

endpackage

/* design/chm_ctrl.sv */
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer of the hash map: clearing pass, hash, chain walk and update.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chm_pkg::stat_t stat_i,
  output chm_pkg::cmd_t  cmd_o
);

  chm_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chm_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chm_pkg::S_CLEAR:   if (stat_i.clr_done) state_d = chm_pkg::S_IDLE;
      chm_pkg::S_IDLE:    if (in_valid_i) state_d = chm_pkg::S_HASH;
      chm_pkg::S_HASH:    if (stat_i.hash_done) state_d = chm_pkg::S_HEAD;
      chm_pkg::S_HEAD:    state_d = chm_pkg::S_LOAD;
      chm_pkg::S_LOAD:    state_d = chm_pkg::S_WALK;
      chm_pkg::S_WALK:    state_d = stat_i.cur_nil ? chm_pkg::S_ACT : chm_pkg::S_CHK;
      chm_pkg::S_CHK:     state_d = stat_i.key_lt ? chm_pkg::S_WALK : chm_pkg::S_ACT;
      chm_pkg::S_ACT: begin
        if (stat_i.func == chm_pkg::FUNC_INSERT && !stat_i.hit && !stat_i.free_nil) begin
          state_d = chm_pkg::S_FREE_RD;
        end else if (stat_i.func == chm_pkg::FUNC_REMOVE && stat_i.hit) begin
          state_d = chm_pkg::S_LINK;
        end else begin
          state_d = chm_pkg::S_FIN;
        end
      end
      chm_pkg::S_FREE_RD: state_d = chm_pkg::S_INS;
      chm_pkg::S_INS:     state_d = chm_pkg::S_LINK;
      chm_pkg::S_LINK: begin
        state_d = (stat_i.func == chm_pkg::FUNC_REMOVE) ? chm_pkg::S_REL : chm_pkg::S_FIN;
      end
      chm_pkg::S_REL:     state_d = chm_pkg::S_FIN;
      chm_pkg::S_FIN:     if (stat_i.out_free) state_d = chm_pkg::S_IDLE;
      default:            state_d = chm_pkg::S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      chm_pkg::S_CLEAR:   cmd_o.clr = 1'b1;
      chm_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      chm_pkg::S_HASH:    cmd_o.hash = 1'b1;
      chm_pkg::S_HEAD:    cmd_o      = '0;
      chm_pkg::S_LOAD:    cmd_o.load = 1'b1;
      chm_pkg::S_WALK:    cmd_o.walk = 1'b1;
      chm_pkg::S_CHK:     cmd_o.chk  = 1'b1;
      chm_pkg::S_ACT:     cmd_o.act  = 1'b1;
      chm_pkg::S_FREE_RD: cmd_o.sel_free = 1'b1;
      chm_pkg::S_INS:     cmd_o.ins  = 1'b1;
      chm_pkg::S_LINK:    cmd_o.link = 1'b1;
      chm_pkg::S_REL:     cmd_o.rel  = 1'b1;
      chm_pkg::S_FIN:     cmd_o.fin  = stat_i.out_free;
      default:            cmd_o      = '0;
    endcase
  end

endmodule

/* design/chm_dp.sv */
// ----------------------------------------------------------------------------
// chm_dp
// Datapath of the hash map: bucket and node memories, hash unit, walk
// pointers, free list and result register.
// ----------------------------------------------------------------------------
module chm_dp #(
  parameter int unsigned BUCKETS = chm_pkg::BucketsDef,
  parameter int unsigned NODES   = chm_pkg::NodesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  chm_pkg::cmd_t  cmd_i,
  output chm_pkg::stat_t stat_o,
  input  logic [1:0]     func_i,
  input  logic [31:0]    key_i,
  input  logic [31:0]    handle_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic [31:0]    found_handle_o
);

  localparam int unsigned PW   = $clog2(NODES + 1);
  localparam int unsigned IW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned RW   = $clog2(BUCKETS) + 2;
  localparam int unsigned MAXD = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int unsigned CW   = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam bit          POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [PW-1:0] NIL = '1;

  // Memories
  logic [PW-1:0] bucket_mem [BUCKETS];
  logic [31:0]   key_mem    [NODES];
  logic [31:0]   hnd_mem    [NODES];
  logic [PW-1:0] next_mem   [NODES];

  logic [PW-1:0] head_rd, next_rd;
  logic [31:0]   key_rd, hnd_rd;

  logic [1:0]    func_q;
  logic [31:0]   key_q, handle_q;
  logic [31:0]   sh_q;
  logic [RW-1:0] rem_q, rem_d;
  logic [2:0]    hcnt_q;
  logic          hdone_q;
  logic [BW-1:0] bucket_q;
  logic [PW-1:0] cur_q, prev_q, nxt_q, lnk_q, free_q;
  logic [31:0]   hnd_q;
  logic          hit_q;
  logic [CW-1:0] clr_q;
  logic [1:0]    res_st_q;
  logic [31:0]   res_hnd_q;
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [31:0]   found_q;

  logic [IW-1:0] next_raddr;
  logic          next_we;
  logic [IW-1:0] next_waddr;
  logic [PW-1:0] next_wdata;
  logic          bucket_we;
  logic [BW-1:0] bucket_waddr;
  logic [PW-1:0] bucket_wdata;
  logic [31:0]   clr_ext;
  logic [PW-1:0] clr_nxt;
  logic          key_lt, key_eq;

  assign clr_ext = 32'(clr_q);
  assign clr_nxt = (clr_ext + 32'd1 < NODES) ? PW'(clr_ext + 32'd1) : NIL;
  assign key_lt  = key_rd < key_q;
  assign key_eq  = key_rd == key_q;

  // Select node_next read and write ports and the bucket write port
  always_comb begin
    next_raddr   = cmd_i.sel_free ? free_q[IW-1:0] : cur_q[IW-1:0];
    next_we      = 1'b0;
    next_waddr   = cur_q[IW-1:0];
    next_wdata   = free_q;
    bucket_we    = 1'b0;
    bucket_waddr = bucket_q;
    bucket_wdata = lnk_q;
    if (cmd_i.clr) begin
      next_we      = clr_ext < NODES;
      next_waddr   = IW'(clr_q);
      next_wdata   = clr_nxt;
      bucket_we    = clr_ext < BUCKETS;
      bucket_waddr = BW'(clr_q);
      bucket_wdata = NIL;
    end else if (cmd_i.ins) begin
      next_we    = 1'b1;
      next_waddr = free_q[IW-1:0];
      next_wdata = cur_q;
    end else if (cmd_i.link) begin
      next_we    = (prev_q != NIL);
      next_waddr = prev_q[IW-1:0];
      next_wdata = lnk_q;
      bucket_we  = (prev_q == NIL);
    end else if (cmd_i.rel) begin
      next_we    = 1'b1;
      next_waddr = cur_q[IW-1:0];
      next_wdata = free_q;
    end
  end

  // Access memories
  always_ff @(posedge clk_i) begin
    if (bucket_we) bucket_mem[bucket_waddr] <= bucket_wdata;
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (cmd_i.ins) begin
      key_mem[free_q[IW-1:0]] <= key_q;
      hnd_mem[free_q[IW-1:0]] <= handle_q;
    end
    head_rd <= bucket_mem[bucket_q];
    next_rd <= next_mem[next_raddr];
    key_rd  <= key_mem[cur_q[IW-1:0]];
    hnd_rd  <= hnd_mem[cur_q[IW-1:0]];
  end

  // Four restoring steps of key mod BUCKETS
  always_comb begin
    logic [RW-1:0] r;
    r = rem_q;
    for (int j = 0; j < 4; j++) begin
      r = {r[RW-2:0], sh_q[31-j]};
      if (r >= RW'(BUCKETS)) r = r - RW'(BUCKETS);
    end
    rem_d = r;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      free_q      <= '0;
      hdone_q     <= 1'b0;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + CW'(1);
      if (cmd_i.accept) begin
        hcnt_q  <= '0;
        hdone_q <= POW2;
      end else if (cmd_i.hash && !hdone_q) begin
        hcnt_q <= hcnt_q + 3'd1;
        if (hcnt_q == 3'd7) hdone_q <= 1'b1;
      end
      if (cmd_i.ins) free_q <= next_rd;
      else if (cmd_i.rel) free_q <= cur_q;
      if (cmd_i.fin) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q   <= func_i;
      key_q    <= key_i;
      handle_q <= handle_i;
      sh_q     <= key_i;
      rem_q    <= '0;
      if (POW2) bucket_q <= BW'(key_i & 32'(BUCKETS - 1));
    end else if (cmd_i.hash && !hdone_q) begin
      sh_q  <= {sh_q[27:0], 4'd0};
      rem_q <= rem_d;
      if (hcnt_q == 3'd7) bucket_q <= BW'(rem_d);
    end
    // Start walk at bucket head
    if (cmd_i.load) begin
      cur_q  <= head_rd;
      prev_q <= NIL;
    end
    if (cmd_i.walk && cur_q == NIL) hit_q <= 1'b0;
    // Advance past smaller keys, else capture the candidate
    if (cmd_i.chk) begin
      if (key_lt) begin
        prev_q <= cur_q;
        cur_q  <= next_rd;
      end else begin
        hit_q <= key_eq;
        nxt_q <= next_rd;
        hnd_q <= hnd_rd;
      end
    end
    // Decide the result of the operation
    if (cmd_i.act) begin
      lnk_q <= nxt_q;
      case (func_q)
        chm_pkg::FUNC_INSERT: begin
          res_hnd_q <= '0;
          if (hit_q) res_st_q <= chm_pkg::ST_DUP;
          else if (free_q == NIL) res_st_q <= chm_pkg::ST_FULL;
          else res_st_q <= chm_pkg::ST_OK;
        end
        chm_pkg::FUNC_FIND: begin
          res_st_q  <= hit_q ? chm_pkg::ST_OK : chm_pkg::ST_NOTFOUND;
          res_hnd_q <= hit_q ? hnd_q : 32'd0;
        end
        chm_pkg::FUNC_REMOVE: begin
          res_st_q  <= hit_q ? chm_pkg::ST_OK : chm_pkg::ST_NOTFOUND;
          res_hnd_q <= '0;
        end
        default: begin
          res_st_q  <= chm_pkg::ST_NOTFOUND;
          res_hnd_q <= '0;
        end
      endcase
    end
    if (cmd_i.ins) lnk_q <= free_q;
    if (cmd_i.fin) begin
      status_q <= res_st_q;
      found_q  <= res_hnd_q;
    end
  end

  assign stat_o.clr_done  = (clr_ext == MAXD - 1);
  assign stat_o.hash_done = hdone_q;
  assign stat_o.cur_nil   = (cur_q == NIL);
  assign stat_o.key_lt    = key_lt;
  assign stat_o.hit       = hit_q;
  assign stat_o.free_nil  = (free_q == NIL);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.func      = func_q;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_handle_o = found_q;

endmodule

/* design/chained_hash_map.sv */
// ----------------------------------------------------------------------------
// chained_hash_map
// Map of 32-bit keys to 32-bit handles with bucket chains in a node pool.
// ----------------------------------------------------------------------------
// One operation (insert, find, remove) is taken at a time and gives one
// result. An operation is accepted, then hashed: the bucket is taken from
// the low key bits when BUCKETS is a power of two, else computed as key mod
// BUCKETS iteratively, four bits a cycle. The bucket head is read, the chain
// is walked with one registered node memory read per node visited, a
// decision is made, and then any update follows (free node read, node write
// and relink for insert; relink and release for remove) before the result
// register is loaded. The next operation is taken while the result still
// waits. After reset a clearing pass over max(BUCKETS, NODES) addresses
// empties the buckets and builds the free list; no operation is taken then.
module chained_hash_map #(
  parameter int unsigned BUCKETS = chm_pkg::BucketsDef,
  parameter int unsigned NODES   = chm_pkg::NodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_handle_o
);

  `include "chained_hash_map_assert.svh"

  chm_pkg::cmd_t  cmd;
  chm_pkg::stat_t stat;

  chm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  chm_dp #(
    .BUCKETS (BUCKETS),
    .NODES   (NODES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .key_i          (key_i),
    .handle_i       (handle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_handle_o (found_handle_o)
  );

  // Check one transaction in flight, pool use and result coding
  `CHM_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken early")
  `CHM_ASSERT_IMP(a_ins_free, cmd.ins, !stat.free_nil, "insert from empty pool")
  `CHM_ASSERT_IMP(a_hnd_ok, out_valid_o && found_handle_o != 32'd0,
                  status_o == chm_pkg::ST_OK, "handle on failed result")

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives insert, find, remove and unused-code transactions into the chained
// hash map and checks every result against a behavioral map held in the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBUCKET = 256;
  localparam int unsigned NNODE   = 1024;
  localparam int unsigned NULLPTR = 32'hFFFF_FFFF;
  localparam int          STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle;
  } answer_t;

  // Scoreboard: behavioral map plus queue of pending answers
  class map_scoreboard;
    int unsigned head_of[NBUCKET];
    logic [31:0] key_of[NNODE];
    logic [31:0] hdl_of[NNODE];
    int unsigned next_of[NNODE];
    int unsigned free_top;
    answer_t     pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < NBUCKET; i++) head_of[i] = NULLPTR;
      for (int i = 0; i < NNODE; i++) begin
        key_of[i] = '0;
        hdl_of[i] = '0;
        next_of[i] = (i + 1 < NNODE) ? i + 1 : NULLPTR;
      end
      free_top = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] k, logic [31:0] h);
      int unsigned bkt, prv, cur, n;
      bit hit;
      answer_t a;
      bkt = k % NBUCKET;
      prv = NULLPTR;
      cur = head_of[bkt];
      while (cur != NULLPTR && key_of[cur] < k) begin
        prv = cur;
        cur = next_of[cur];
      end
      hit = (cur != NULLPTR) && key_of[cur] == k;
      a.status = chm_pkg::ST_NOTFOUND;
      a.handle = '0;
      case (op)
        chm_pkg::FUNC_INSERT: begin
          if (hit) a.status = chm_pkg::ST_DUP;
          else if (free_top == NULLPTR) a.status = chm_pkg::ST_FULL;
          else begin
            n = free_top;
            free_top = next_of[n];
            key_of[n] = k;
            hdl_of[n] = h;
            next_of[n] = cur;
            if (prv == NULLPTR) head_of[bkt] = n;
            else next_of[prv] = n;
            a.status = chm_pkg::ST_OK;
          end
        end
        chm_pkg::FUNC_FIND: begin
          if (hit) begin
            a.status = chm_pkg::ST_OK;
            a.handle = hdl_of[cur];
          end
        end
        chm_pkg::FUNC_REMOVE: begin
          if (hit) begin
            if (prv == NULLPTR) head_of[bkt] = next_of[cur];
            else next_of[prv] = next_of[cur];
            next_of[cur] = free_top;
            free_top = cur;
            a.status = chm_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic [31:0] fh);
      answer_t a;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d handle=%h", $realtime, st, fh);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (st !== a.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, a.status, st);
        errors++;
      end
      if (fh !== a.handle) begin
        $display("%0t: found_handle expected %h actual %h", $realtime, a.handle, fh);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  func_i;
  logic [31:0] key_i, handle_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] found_handle_o;

  map_scoreboard sb;
  int  send_idle, recv_stall;
  int  quiet_cycles;
  logic [31:0] live_keys[$];

  chained_hash_map i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .key_i, .handle_i,
    .out_valid_o, .out_ready_i, .status_o, .found_handle_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check results and count quiet cycles at each rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_answer(status_o, found_handle_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Toggle result backpressure at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  // Present one transaction and hold it until accepted
  task automatic issue(logic [1:0] op, logic [31:0] k, logic [31:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    key_i <= k;
    handle_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, k, h);
    if (op == chm_pkg::FUNC_INSERT) live_keys.push_back(k);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (live_keys.size() > 0 && r < 6) return live_keys[$urandom_range(live_keys.size() - 1)];
    if (r < 9) return ($urandom_range(15) << 8) | $urandom_range(3);
    return $urandom();
  endfunction

  // Random phase: mostly keys that collide in four buckets
  task automatic random_run(int count, int idle_pct, int stall_pct);
    int r;
    logic [1:0] op;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      op = (r < 45) ? chm_pkg::FUNC_INSERT : (r < 72) ? chm_pkg::FUNC_FIND :
           (r < 97) ? chm_pkg::FUNC_REMOVE : chm_pkg::FUNC_UNUSED;
      issue(op, pick_key(), $urandom());
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = chm_pkg::FUNC_INSERT;
    key_i = '0;
    handle_i = '0;
    out_ready_i = 1'b1;
    send_idle = 0;
    recv_stall = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, extremes, head removal, duplicates, unused op
    issue(chm_pkg::FUNC_REMOVE, 32'd5, 32'd0);
    issue(chm_pkg::FUNC_FIND, 32'd5, 32'd0);
    issue(chm_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(chm_pkg::FUNC_INSERT, 32'h0000_00FF, 32'h1234_5678);
    issue(chm_pkg::FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    issue(chm_pkg::FUNC_INSERT, 32'h0000_0100, 32'hAAAA_5555);
    issue(chm_pkg::FUNC_INSERT, 32'h0000_0200, 32'h5555_AAAA);
    issue(chm_pkg::FUNC_INSERT, 32'h0000_0100, 32'hDEAD_BEEF);
    issue(chm_pkg::FUNC_FIND, 32'hFFFF_FFFF, 32'd0);
    issue(chm_pkg::FUNC_FIND, 32'h0000_0100, 32'd0);
    issue(chm_pkg::FUNC_FIND, 32'h0000_0300, 32'd0);
    issue(chm_pkg::FUNC_REMOVE, 32'h0000_0000, 32'd0);
    issue(chm_pkg::FUNC_FIND, 32'h0000_0100, 32'd0);
    issue(chm_pkg::FUNC_REMOVE, 32'h0000_0200, 32'd0);
    issue(chm_pkg::FUNC_REMOVE, 32'h0000_0200, 32'd0);
    issue(chm_pkg::FUNC_UNUSED, 32'h0000_0100, 32'hFFFF_FFFF);
    issue(chm_pkg::FUNC_FIND, 32'h0000_0100, 32'd0);

    random_run(50, 0, 0);
    random_run(50, 87, 0);
    random_run(50, 0, 87);
    random_run(50, 18, 18);

    // Fill the pool to exhaustion, then refuse more
    send_idle = 0;
    recv_stall = 0;
    for (int i = 0; i < NNODE; i++) begin
      issue(chm_pkg::FUNC_INSERT, 32'h8000_0000 + i, $urandom());
    end
    issue(chm_pkg::FUNC_INSERT, 32'h7000_0000, 32'h1);
    issue(chm_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'h2);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
